// ===== hw/rtl/dhss_pkg.sv =====
// Shared types, codes and field widths of the double-hash sparse store.
package dhss_pkg;

    localparam int ROW_W   = 16;
    localparam int COL_W   = 16;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 17;
    localparam int QUO_W   = 16;
    localparam int RCP_W   = 32;
    localparam int RCP_SH  = 33;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic MODE_READ   = 1'b0;
    localparam logic MODE_MODIFY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

    typedef enum logic [2:0] {
        STATUS_FOUND    = 3'd0,
        STATUS_ABSENT   = 3'd1,
        STATUS_INSERTED = 3'd2,
        STATUS_RANGE    = 3'd3,
        STATUS_FULL     = 3'd4
    } status_t;

    // One request as it travels from the front end to the probe engine
    typedef struct packed {
        logic                    mode;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    oor;
    } dhss_req_t;

    // One table slot as held in the slot memory
    typedef struct packed {
        logic                    used;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } slot_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL1,
        FR_MUL2,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_CHECK,
        BK_DONE
    } back_state_t;

endpackage

// ===== hw/rtl/dhss_req_if.sv =====
// Request channel: valid/ready handshake carrying one matrix access.
interface dhss_req_if
    import dhss_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [ROW_W-1:0]        row_index;
    logic [COL_W-1:0]        col_index;
    logic signed [VAL_W-1:0] new_value;

    modport source (output valid, output mode, output row_index, output col_index,
                    output new_value, input ready);
    modport sink   (input valid, input mode, input row_index, input col_index,
                    input new_value, output ready);
endinterface

// ===== hw/rtl/dhss_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one access result.
interface dhss_rsp_if
    import dhss_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    status_t                 status;
    logic                    load_high;

    modport source (output valid, output result_value, output status,
                    output load_high, input ready);
    modport sink   (input valid, input result_value, input status,
                    input load_high, output ready);
endinterface

// ===== hw/rtl/dhss_front.sv =====
// Front end: accepts requests, checks index range and computes both hashes.
module dhss_front
    import dhss_pkg::*;
#(
    parameter int TABLE_SLOTS = 1021,
    parameter int IDX_W       = $clog2(TABLE_SLOTS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    dhss_req_if.sink         request,
    input  logic [15:0]      row_count,
    input  logic [15:0]      col_count,
    input  logic             clear_busy,
    output logic             job_valid,
    input  logic             job_ready,
    output dhss_req_t        job_req,
    output logic [IDX_W-1:0] job_h1,
    output logic [IDX_W-1:0] job_h2
);

    // Moduli and their scaled reciprocals; estimate is low by at most one
    localparam logic [SUM_W-1:0] SlotsA = SUM_W'(TABLE_SLOTS);
    localparam logic [SUM_W-1:0] SlotsB = SUM_W'(TABLE_SLOTS - 1);
    localparam logic [RCP_W-1:0] RecipA = RCP_W'((64'd1 << RCP_SH) / TABLE_SLOTS);
    localparam logic [RCP_W-1:0] RecipB = RCP_W'((64'd1 << RCP_SH) / (TABLE_SLOTS - 1));
    localparam int PROD1_W = SUM_W + RCP_W;
    localparam int PROD2_W = QUO_W + SUM_W;

    front_state_t     state_reg, state_next;
    dhss_req_t        req_reg, req_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [QUO_W-1:0] qa_reg, qa_next, qb_reg, qb_next;
    logic [SUM_W-1:0] pa_reg, pa_next, pb_reg, pb_next;

    logic               accept;
    logic [PROD1_W-1:0] mul1_a, mul1_b;
    logic [PROD2_W-1:0] mul2_a, mul2_b;
    logic [SUM_W-1:0]   rem_a, rem_b, mod_a, mod_b, step_b;

    assign request.ready = (state_reg == FR_IDLE) && !clear_busy;
    assign accept        = request.valid && request.ready;

    // Advance the state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE: if (accept) state_next = FR_MUL1;
            FR_MUL1: state_next = FR_MUL2;
            FR_MUL2: state_next = FR_PUSH;
            FR_PUSH: if (job_ready) state_next = FR_IDLE;
            default: state_next = FR_IDLE;
        endcase
    end

    // Datapath: quotient estimate, back-multiply, then correct the remainder
    always_comb
    begin
        req_next = req_reg;
        sum_next = sum_reg;
        qa_next  = qa_reg;
        qb_next  = qb_reg;
        pa_next  = pa_reg;
        pb_next  = pb_reg;
        mul1_a   = {{RCP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RecipA};
        mul1_b   = {{RCP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RecipB};
        mul2_a   = {{SUM_W{1'b0}}, qa_reg} * {{QUO_W{1'b0}}, SlotsA};
        mul2_b   = {{SUM_W{1'b0}}, qb_reg} * {{QUO_W{1'b0}}, SlotsB};
        rem_a    = sum_reg - pa_reg;
        rem_b    = sum_reg - pb_reg;
        mod_a    = (rem_a >= SlotsA) ? (rem_a - SlotsA) : rem_a;
        mod_b    = (rem_b >= SlotsB) ? (rem_b - SlotsB) : rem_b;
        step_b   = mod_b + SUM_W'(1);
        job_valid = 1'b0;
        case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    req_next.mode  = request.mode;
                    req_next.row   = request.row_index;
                    req_next.col   = request.col_index;
                    req_next.value = request.new_value;
                    req_next.oor   = (request.row_index >= row_count) ||
                                     (request.col_index >= col_count);
                    sum_next = {1'b0, request.row_index} + {1'b0, request.col_index};
                end
            end
            FR_MUL1:
            begin
                qa_next = mul1_a[RCP_SH +: QUO_W];
                qb_next = mul1_b[RCP_SH +: QUO_W];
            end
            FR_MUL2:
            begin
                pa_next = mul2_a[SUM_W-1:0];
                pb_next = mul2_b[SUM_W-1:0];
            end
            FR_PUSH: job_valid = 1'b1;
            default: job_valid = 1'b0;
        endcase
    end

    assign job_req = req_reg;
    assign job_h1  = mod_a[IDX_W-1:0];
    assign job_h2  = step_b[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FR_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        sum_reg <= sum_next;
        qa_reg  <= qa_next;
        qb_reg  <= qb_next;
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
    end

endmodule

// ===== hw/rtl/dhss_queue.sv =====
// Two-entry queue that decouples the front end from the probe engine.
module dhss_queue
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        fill_reg, fill_next;
    logic              push, pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (pop && !push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_data;
    end

endmodule

// ===== hw/rtl/dhss_back.sv =====
// Probe engine: walks the slot memory, updates it and holds the result beat.
module dhss_back
    import dhss_pkg::*;
#(
    parameter int TABLE_SLOTS = 1021,
    parameter int IDX_W       = $clog2(TABLE_SLOTS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  dhss_req_t        job_req,
    input  logic [IDX_W-1:0] job_h1,
    input  logic [IDX_W-1:0] job_h2,
    output logic             clear_busy,
    dhss_rsp_if.source       response
);

    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [IDX_W-1:0] LastSlot  = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [IDX_W:0]   SlotsWide = (IDX_W + 1)'(TABLE_SLOTS);
    localparam logic [CNT_W+1:0] LoadLimit = (CNT_W + 2)'(3 * TABLE_SLOTS);

    back_state_t              state_reg, state_next;
    logic [IDX_W-1:0]         clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic [IDX_W-1:0]         step_reg, step_next;
    logic [IDX_W-1:0]         probe_reg, probe_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    dhss_req_t                cur_reg, cur_next;
    logic signed [VAL_W-1:0]  result_reg, result_next;
    status_t                  status_reg, status_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic signed [VAL_W-1:0]  rsp_value_reg, rsp_value_next;
    status_t                  rsp_status_reg, rsp_status_next;
    logic                     rsp_load_reg, rsp_load_next;

    slot_t                    slot_mem [TABLE_SLOTS];
    slot_t                    rd_data_reg;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_addr;
    slot_t                    mem_wdata;
    logic [IDX_W-1:0]         rd_addr;

    logic                     slot_empty, slot_match, out_free, is_modify;
    logic [IDX_W:0]           pos_sum;
    logic [IDX_W-1:0]         pos_step;

    assign slot_empty = !rd_data_reg.used;
    assign slot_match = rd_data_reg.used && (rd_data_reg.row == cur_reg.row) &&
                        (rd_data_reg.col == cur_reg.col);
    assign is_modify  = (cur_reg.mode == MODE_MODIFY);
    assign out_free   = !rsp_valid_reg || response.ready;
    assign pos_sum    = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_step   = (pos_sum >= SlotsWide) ? IDX_W'(pos_sum - SlotsWide)
                                               : pos_sum[IDX_W-1:0];
    assign clear_busy = (state_reg == BK_CLEAR);

    // Advance the state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: if (clr_addr_reg == LastSlot) state_next = BK_IDLE;
            BK_IDLE:
            begin
                if (job_valid)
                    state_next = job_req.oor ? BK_DONE : BK_CHECK;
            end
            BK_CHECK:
            begin
                if (slot_empty || slot_match || (probe_reg == LastSlot))
                    state_next = BK_DONE;
            end
            BK_DONE: if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Drive memory ports, probe registers and the result beat
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        probe_next      = probe_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        result_next     = result_reg;
        status_next     = status_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_status_next = rsp_status_reg;
        rsp_load_next   = rsp_load_reg;
        rsp_valid_next  = rsp_valid_reg && !response.ready;
        job_ready       = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = pos_reg;
        mem_wdata       = {1'b1, cur_reg.row, cur_reg.col, cur_reg.value};
        rd_addr         = pos_step;
        case (state_reg)
            BK_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
            end
            BK_IDLE:
            begin
                job_ready = 1'b1;
                rd_addr   = job_h1;
                if (job_valid)
                begin
                    cur_next    = job_req;
                    pos_next    = job_h1;
                    step_next   = job_h2;
                    probe_next  = '0;
                    result_next = '0;
                    status_next = STATUS_RANGE;
                end
            end
            BK_CHECK:
            begin
                if (slot_empty)
                begin
                    if (is_modify)
                    begin
                        mem_we      = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = STATUS_INSERTED;
                    end
                    else
                        status_next = STATUS_ABSENT;
                end
                else if (slot_match)
                begin
                    mem_we      = is_modify;
                    result_next = rd_data_reg.value;
                    status_next = STATUS_FOUND;
                end
                else if (probe_reg == LastSlot)
                    status_next = is_modify ? STATUS_FULL : STATUS_ABSENT;
                else
                begin
                    pos_next   = pos_step;
                    probe_next = probe_reg + IDX_W'(1);
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = result_reg;
                    rsp_status_next = status_reg;
                    rsp_load_next   = ({count_reg, 2'b00} > LoadLimit);
                end
            end
            default: job_ready = 1'b0;
        endcase
    end

    assign response.valid        = rsp_valid_reg;
    assign response.result_value = rsp_value_reg;
    assign response.status       = rsp_status_reg;
    assign response.load_high    = rsp_load_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        probe_reg      <= probe_next;
        cur_reg        <= cur_next;
        result_reg     <= result_next;
        status_reg     <= status_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_status_reg <= rsp_status_next;
        rsp_load_reg   <= rsp_load_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_addr] <= mem_wdata;
        rd_data_reg <= slot_mem[rd_addr];
    end

`ifndef NO_ASSERTIONS
    // Probe position and stride stay inside the table while probing
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CHECK) |->
            (pos_reg < TABLE_SLOTS) && (step_reg != '0) && (step_reg < TABLE_SLOTS))
        else $error("probe position or stride outside the table");

    // The memory is written only by the clearing pass or an accepted modify
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == BK_CLEAR) ||
                   ((state_reg == BK_CHECK) && is_modify))
        else $error("slot memory written outside clear or modify");

    // An insert raises the occupancy by exactly one
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == BK_CHECK) && slot_empty && is_modify) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("occupancy did not follow an insert");

    // Occupancy never exceeds the number of slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= TABLE_SLOTS)
        else $error("occupancy above table size");
`endif

endmodule

// ===== hw/rtl/double_hash_sparse_store_core.sv =====
// Top level of the double-hash sparse matrix store.
//
// Usage: each request beat on "request" carries mode (0 read, 1 modify),
// row_index, col_index and new_value; each yields exactly one response beat
// on "response" with result_value, status (found, absent, inserted, index out
// of range, table full) and load_high (occupancy above three quarters).
// row_count and column_count are written through the cfg_* port (index 0
// and 1); the user must do so only while no request is in flight, as the
// block itself does not enforce it. Both reset to 1.
// Flow: the front end accepts a request, computes both hash remainders in
// two multiply stages and hands the job off, taking no new request until the
// hand-off; the probe engine probes one slot per cycle through the registered
// read port of the slot memory.
// Reset: the probe engine runs a clearing pass that marks every slot empty;
// request.ready stays low until it finishes.
// A stalled response is held in the output register while the front end and
// the two-entry queue keep taking and preparing further requests until full.
module double_hash_sparse_store_core
    import dhss_pkg::*;
#(
    parameter int TABLE_SLOTS = 1021
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    dhss_req_if.sink              request,
    dhss_rsp_if.source            response,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int JOB_W  = $bits(dhss_req_t) + 2 * IDX_W;

    logic [15:0]      row_count_reg, row_count_next;
    logic [15:0]      col_count_reg, col_count_next;

    logic             fr_valid, fr_ready, bk_valid, bk_ready, clear_busy;
    dhss_req_t        fr_req, bk_req;
    logic [IDX_W-1:0] fr_h1, fr_h2, bk_h1, bk_h2;
    logic [JOB_W-1:0] q_in, q_out;

    // Decode configuration writes
    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ROW_COUNT: row_count_next = cfg_data;
                CFG_COL_COUNT: col_count_next = cfg_data;
                default:       row_count_next = row_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= 16'd1;
            col_count_reg <= 16'd1;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    dhss_front #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .row_count  (row_count_reg),
        .col_count  (col_count_reg),
        .clear_busy (clear_busy),
        .job_valid  (fr_valid),
        .job_ready  (fr_ready),
        .job_req    (fr_req),
        .job_h1     (fr_h1),
        .job_h2     (fr_h2)
    );

    assign q_in = {fr_req, fr_h1, fr_h2};
    assign {bk_req, bk_h1, bk_h2} = q_out;

    dhss_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (q_in),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_data  (q_out)
    );

    dhss_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (bk_valid),
        .job_ready  (bk_ready),
        .job_req    (bk_req),
        .job_h1     (bk_h1),
        .job_h2     (bk_h2),
        .clear_busy (clear_busy),
        .response   (response)
    );

endmodule

// ===== sim/double_hash_sparse_store_core_tb.sv =====
// Self-checking testbench: directed and random matrix accesses against a predictor.
`timescale 1ns / 1ps

module double_hash_sparse_store_core_tb;
    import dhss_pkg::*;

    localparam int SLOTS           = 1021;
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = SLOTS + 16;
    localparam int HOLD_OFF_BEAT   = 150;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        status_t                 status;
        logic                    load_high;
    } access_result_t;

    typedef enum logic {
        STEP_ACCESS,
        STEP_WRITE_REG
    } step_kind_t;

    // One row of the directed plan; a register write carries its data in row
    typedef struct packed {
        step_kind_t           kind;
        logic                 mode;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [VAL_W-1:0]     value;
        logic                 fixed;
        logic [VAL_W-1:0]     exp_value;
        status_t              exp_status;
        logic [CFG_IDX_W-1:0] reg_sel;
    } plan_step_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dhss_req_if request_bus ();
    dhss_rsp_if response_bus ();

    double_hash_sparse_store_core #(
        .TABLE_SLOTS(SLOTS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_bus),
        .response (response_bus),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the table and its registers
    logic [ROW_W-1:0] row_limit;
    logic [COL_W-1:0] col_limit;
    logic [ROW_W-1:0] key_row   [SLOTS];
    logic [COL_W-1:0] key_col   [SLOTS];
    logic [VAL_W-1:0] key_value [SLOTS];
    bit               key_used  [SLOTS];
    int unsigned      used_count;

    access_result_t pending_results [$];
    logic [31:0]    stored_keys [$];
    int             errors;
    int             sent_count;
    int             beats_seen;
    int             quiet_cycles;

    plan_step_t directed_plan [28] = '{
        // default 1x1 matrix: empty read, range errors, insert and overwrite
        '{STEP_ACCESS, MODE_READ, 16'd0, 16'd0, '0, 1'b1, '0, STATUS_ABSENT, CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_READ, 16'hFFFF, 16'd0, '0, 1'b1, '0, STATUS_RANGE, CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_READ, 16'd0, 16'hFFFF, '0, 1'b1, '0, STATUS_RANGE, CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_MODIFY, 16'd1, 16'd0, 32'd1234, 1'b1, '0, STATUS_RANGE,
          CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_MODIFY, 16'd0, 16'd0, 32'h8000_0000, 1'b1, '0, STATUS_INSERTED,
          CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_READ, 16'd0, 16'd0, '0, 1'b1, 32'h8000_0000, STATUS_FOUND,
          CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_MODIFY, 16'd0, 16'd0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000,
          STATUS_FOUND, CFG_ROW_COUNT},
        // zero is stored like any value and keeps its slot
        '{STEP_ACCESS, MODE_MODIFY, 16'd0, 16'd0, 32'd0, 1'b1, 32'h7FFF_FFFF, STATUS_FOUND,
          CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_READ, 16'd0, 16'd0, 32'hFFFF_FFFF, 1'b1, 32'd0, STATUS_FOUND,
          CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_MODIFY, 16'd0, 16'd0, 32'hFFFF_FFFF, 1'b1, 32'd0, STATUS_FOUND,
          CFG_ROW_COUNT},
        // widest matrix
        '{STEP_WRITE_REG, MODE_READ, 16'hFFFF, 16'd0, '0, 1'b0, '0, STATUS_FOUND,
          CFG_ROW_COUNT},
        '{STEP_WRITE_REG, MODE_READ, 16'hFFFF, 16'd0, '0, 1'b0, '0, STATUS_FOUND,
          CFG_COL_COUNT},
        '{STEP_ACCESS, MODE_READ, 16'hFFFE, 16'hFFFE, '0, 1'b1, '0, STATUS_ABSENT,
          CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_MODIFY, 16'hFFFE, 16'hFFFE, 32'h5555_AAAA, 1'b1, '0,
          STATUS_INSERTED, CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_READ, 16'hFFFF, 16'hFFFE, '0, 1'b1, '0, STATUS_RANGE,
          CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_MODIFY, 16'hFFFE, 16'hFFFF, 32'd7, 1'b1, '0, STATUS_RANGE,
          CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_MODIFY, 16'd0, 16'd0, 32'd1, 1'b1, 32'hFFFF_FFFF, STATUS_FOUND,
          CFG_ROW_COUNT},
        // keys sharing a probe path, and a miss that collides on the first slot
        '{STEP_ACCESS, MODE_MODIFY, 16'd1, 16'd0, 32'd2, 1'b0, '0, STATUS_FOUND,
          CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_MODIFY, 16'd0, 16'd1, 32'd3, 1'b0, '0, STATUS_FOUND,
          CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_READ, 16'd0, 16'd1, '0, 1'b0, '0, STATUS_FOUND, CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_READ, 16'd1021, 16'd0, '0, 1'b0, '0, STATUS_FOUND, CFG_ROW_COUNT},
        // a zero register puts every index out of range
        '{STEP_WRITE_REG, MODE_READ, 16'd0, 16'd0, '0, 1'b0, '0, STATUS_FOUND, CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_READ, 16'd0, 16'd0, '0, 1'b1, '0, STATUS_RANGE, CFG_ROW_COUNT},
        '{STEP_ACCESS, MODE_MODIFY, 16'd0, 16'd0, 32'd9, 1'b1, '0, STATUS_RANGE,
          CFG_ROW_COUNT},
        '{STEP_WRITE_REG, MODE_READ, 16'hFFFF, 16'd0, '0, 1'b0, '0, STATUS_FOUND,
          CFG_ROW_COUNT},
        '{STEP_WRITE_REG, MODE_READ, 16'd0, 16'd0, '0, 1'b0, '0, STATUS_FOUND, CFG_COL_COUNT},
        '{STEP_ACCESS, MODE_MODIFY, 16'd0, 16'd0, 32'd9, 1'b1, '0, STATUS_RANGE,
          CFG_ROW_COUNT},
        '{STEP_WRITE_REG, MODE_READ, 16'hFFFF, 16'd0, '0, 1'b0, '0, STATUS_FOUND,
          CFG_COL_COUNT}
    };

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Probe the shadow table along the double-hash path and apply the access
    function automatic access_result_t probe_table(input logic m, input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c,
                                                   input logic [VAL_W-1:0] v);
        access_result_t res;
        int unsigned    sum;
        int unsigned    pos;
        int unsigned    hop;
        int unsigned    k;
        bit             done;
        res.value = '0;
        if (r >= row_limit || c >= col_limit)
        begin
            res.status = STATUS_RANGE;
        end
        else
        begin
            sum = r + c;
            pos = sum % SLOTS;
            hop = 1 + sum % (SLOTS - 1);
            res.status = (m == MODE_MODIFY) ? STATUS_FULL : STATUS_ABSENT;
            done = 1'b0;
            for (k = 0; k < SLOTS && !done; k++)
            begin
                if (!key_used[pos])
                begin
                    if (m == MODE_MODIFY)
                    begin
                        key_used[pos]  = 1'b1;
                        key_row[pos]   = r;
                        key_col[pos]   = c;
                        key_value[pos] = v;
                        used_count++;
                        res.status = STATUS_INSERTED;
                    end
                    else
                    begin
                        res.status = STATUS_ABSENT;
                    end
                    done = 1'b1;
                end
                else if (key_row[pos] == r && key_col[pos] == c)
                begin
                    res.value = key_value[pos];
                    if (m == MODE_MODIFY)
                        key_value[pos] = v;
                    res.status = STATUS_FOUND;
                    done = 1'b1;
                end
                else
                begin
                    pos += hop;
                    if (pos >= SLOTS)
                        pos -= SLOTS;
                end
            end
        end
        res.load_high = (used_count * 4 > SLOTS * 3);
        return res;
    endfunction

    // Mostly no gap, some short ones, a few long; every third stretch runs flat out
    function automatic int idle_gap(input int beat_no);
        int roll;
        if ((beat_no / 80) % 3 == 2)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one access, hold it until accepted, then queue its prediction
    task automatic send_access(input logic m, input logic [ROW_W-1:0] r,
                               input logic [COL_W-1:0] c, input logic [VAL_W-1:0] v,
                               input logic fixed, input logic [VAL_W-1:0] fixed_value,
                               input status_t fixed_status);
        int             gap;
        access_result_t res;
        gap = idle_gap(sent_count);
        if (gap > 0)
        begin
            request_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_bus.valid     <= 1'b1;
        request_bus.mode      <= m;
        request_bus.row_index <= r;
        request_bus.col_index <= c;
        request_bus.new_value <= v;
        do @(posedge clk); while (!request_bus.ready);
        res = probe_table(m, r, c, v);
        if (fixed)
        begin
            res.value  = fixed_value;
            res.status = fixed_status;
        end
        pending_results.push_back(res);
        sent_count++;
        if (m == MODE_MODIFY)
            stored_keys.push_back({r, c});
    endtask

    // Drain the block, then write one register
    task automatic write_register(input logic [CFG_IDX_W-1:0] sel,
                                  input logic [CFG_DATA_W-1:0] data);
        request_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (sel == CFG_ROW_COUNT)
            row_limit = data;
        else
            col_limit = data;
    endtask

    // Random access: a share out of range, a share on keys already written
    task automatic send_random(input int hit_pct, input int range_pct, input int modify_pct);
        logic             m;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [VAL_W-1:0] v;
        logic [31:0]      key;
        m = ($urandom_range(0, 99) < modify_pct) ? MODE_MODIFY : MODE_READ;
        if ($urandom_range(0, 99) < range_pct)
        begin
            r = ROW_W'($urandom_range(0, 16'hFFFF));
            c = COL_W'($urandom_range(0, 16'hFFFF));
            if ($urandom_range(0, 1) == 1)
                r = ROW_W'($urandom_range(row_limit, 16'hFFFF));
            else
                c = COL_W'($urandom_range(col_limit, 16'hFFFF));
        end
        else if (stored_keys.size() != 0 && $urandom_range(0, 99) < hit_pct)
        begin
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            r = key[31:16];
            c = key[15:0];
        end
        else
        begin
            r = ROW_W'($urandom_range(0, row_limit - 1));
            c = COL_W'($urandom_range(0, col_limit - 1));
        end
        case ($urandom_range(0, 9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'd0;
            default: v = $urandom();
        endcase
        send_access(m, r, c, v, 1'b0, '0, STATUS_FOUND);
    endtask

    // Stimulus
    initial
    begin
        plan_step_t step;
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_index              = CFG_ROW_COUNT;
        cfg_data               = '0;
        request_bus.valid      = 1'b0;
        request_bus.mode       = MODE_READ;
        request_bus.row_index  = '0;
        request_bus.col_index  = '0;
        request_bus.new_value  = '0;
        row_limit              = 16'd1;
        col_limit              = 16'd1;
        used_count             = 0;
        sent_count             = 0;
        for (int i = 0; i < SLOTS; i++)
            key_used[i] = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed plan
        foreach (directed_plan[i])
        begin
            step = directed_plan[i];
            if (step.kind == STEP_WRITE_REG)
                write_register(step.reg_sel, step.row);
            else
                send_access(step.mode, step.row, step.col, step.value, step.fixed,
                            step.exp_value, step.exp_status);
        end

        // Full-size matrix, mixed traffic
        repeat (250) send_random(40, 4, 50);

        // Small matrix: dense hits and frequent range errors
        write_register(CFG_ROW_COUNT, CFG_DATA_W'($urandom_range(2, 40)));
        write_register(CFG_COL_COUNT, CFG_DATA_W'($urandom_range(2, 40)));
        repeat (60) send_random(50, 8, 50);

        // Single row, widest column range
        write_register(CFG_ROW_COUNT, 16'd1);
        write_register(CFG_COL_COUNT, 16'hFFFF);
        repeat (60) send_random(50, 8, 50);

        // Fill the table, then hit it while full
        write_register(CFG_ROW_COUNT, 16'hFFFF);
        write_register(CFG_COL_COUNT, 16'hFFFF);
        while (used_count < SLOTS)
            send_random(0, 0, 100);
        repeat (40) send_random(40, 5, 50);

        // Drain and settle
        request_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Response side: random back-pressure plus one long hold-off
    initial
    begin : response_sink
        int gap;
        response_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (beats_seen == HOLD_OFF_BEAT)
                gap = HOLD_OFF_CYCLES;
            else
                gap = idle_gap(beats_seen);
            if (gap > 0)
            begin
                response_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            response_bus.ready <= 1'b1;
            do @(posedge clk); while (!response_bus.valid);
            beats_seen++;
        end
    end

    // Compare each response beat with the oldest prediction
    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n && response_bus.valid && response_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: response with none pending: value %0d status %0d", $time,
                         response_bus.result_value, response_bus.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (response_bus.result_value !== want.value)
                begin
                    errors++;
                    $display("%0t: result_value expected %0d got %0d", $time, want.value,
                             response_bus.result_value);
                end
                if (response_bus.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             response_bus.status);
                end
                if (response_bus.load_high !== want.load_high)
                begin
                    errors++;
                    $display("%0t: load_high expected %0b got %0b", $time, want.load_high,
                             response_bus.load_high);
                end
            end
        end
    end

    // Watchdog: count cycles with work outstanding and no beat on either side
    always @(posedge clk)
    begin
        if ((request_bus.valid && request_bus.ready) ||
            (response_bus.valid && response_bus.ready) ||
            (!request_bus.valid && pending_results.size() == 0))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
